@@ src/bsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    // raw conversion width default
    localparam int RAW_BITS_DEF = 24;

    // configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_C = 2'd3;

    // decoded trim words
    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_trims;

endpackage

`default_nettype wire

@@ src/bsc_trim.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsc_trim (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bsc_pkg::t_trims                     o_trims
);
    import bsc_pkg::*;

    logic [39:0] r_temp_trim;
    logic [47:0] r_press_a;
    logic [47:0] r_press_b;
    logic [31:0] r_press_c;

    // trim register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_press_a   <= '0;
            r_press_b   <= '0;
            r_press_c   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_TRIM:    r_temp_trim <= i_cfg_data[39:0];
                REG_PRESS_TRIM_A: r_press_a   <= i_cfg_data[47:0];
                REG_PRESS_TRIM_B: r_press_b   <= i_cfg_data[47:0];
                REG_PRESS_TRIM_C: r_press_c   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // unpack fields
    always_comb begin
        o_trims.t1  = r_temp_trim[15:0];
        o_trims.t2  = r_temp_trim[31:16];
        o_trims.t3  = r_temp_trim[39:32];
        o_trims.p1  = r_press_a[15:0];
        o_trims.p2  = r_press_a[31:16];
        o_trims.p3  = r_press_a[39:32];
        o_trims.p4  = r_press_a[47:40];
        o_trims.p5  = r_press_b[15:0];
        o_trims.p6  = r_press_b[31:16];
        o_trims.p7  = r_press_b[39:32];
        o_trims.p8  = r_press_b[47:40];
        o_trims.p9  = r_press_c[15:0];
        o_trims.p10 = r_press_c[23:16];
        o_trims.p11 = r_press_c[31:24];
    end

endmodule

`default_nettype wire

@@ src/bsc_temp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsc_temp #(
    parameter int RAW_BITS = bsc_pkg::RAW_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic [RAW_BITS-1:0] i_rp,
    input  wire logic [RAW_BITS-1:0] i_rt,
    input  bsc_pkg::t_trims          i_trims,
    output logic                     o_vld,
    output logic [RAW_BITS-1:0]      o_rp,
    output logic signed [15:0]       o_temp,
    output logic signed [24:0]       o_tq
);
    import bsc_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0]      r_vld;
    logic [RAW_BITS-1:0] r_rp [NST];

    logic signed [25:0] w_d;
    logic signed [16:0] w_t2;
    logic signed [25:0] r_d;
    logic signed [42:0] r_m1a;
    logic signed [51:0] r_m2;
    logic signed [42:0] r_m1b;
    logic signed [59:0] r_m3;
    logic signed [61:0] r_t48;
    logic signed [62:0] w_tr;
    logic signed [62:0] w_qr;
    logic signed [22:0] w_temp;
    logic signed [30:0] w_tq;
    logic signed [15:0] r_temp;
    logic signed [24:0] r_tq;

    assign w_d  = $signed({2'b00, i_rt}) - $signed({2'b00, i_trims.t1, 8'h00});
    assign w_t2 = $signed({1'b0, i_trims.t2});

    // rounded views of the linear temperature
    assign w_tr   = r_t48 + 63'sd549755813888;
    assign w_qr   = r_t48 + 63'sd2147483648;
    assign w_temp = w_tr[62:40];
    assign w_tq   = w_qr[62:32];

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset from trim
            r_d     <= w_d;
            r_rp[0] <= i_rp;
            // linear and square products
            r_m1a   <= r_d * w_t2;
            r_m2    <= r_d * r_d;
            r_rp[1] <= r_rp[0];
            // quadratic coefficient
            r_m3    <= r_m2 * i_trims.t3;
            r_m1b   <= r_m1a;
            r_rp[2] <= r_rp[1];
            // full-precision temperature
            r_t48   <= (r_m1b <<< 18) + r_m3;
            r_rp[3] <= r_rp[2];
            // saturate outputs
            if (w_temp > 23'sd32767) begin
                r_temp <= 16'sh7fff;
            end else if (w_temp < -23'sd32768) begin
                r_temp <= -16'sd32768;
            end else begin
                r_temp <= w_temp[15:0];
            end
            if (w_tq > 31'sd8388608) begin
                r_tq <= 25'sd8388608;
            end else if (w_tq < -31'sd8388608) begin
                r_tq <= -25'sd8388608;
            end else begin
                r_tq <= w_tq[24:0];
            end
            r_rp[4] <= r_rp[3];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_rp   = r_rp[NST-1];
    assign o_temp = r_temp;
    assign o_tq   = r_tq;

endmodule

`default_nettype wire

@@ src/bsc_press.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsc_press #(
    parameter int RAW_BITS = bsc_pkg::RAW_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic [RAW_BITS-1:0] i_rp,
    input  wire logic signed [15:0]  i_temp,
    input  wire logic signed [24:0]  i_tq,
    input  bsc_pkg::t_trims          i_trims,
    output logic                     o_vld,
    output logic signed [15:0]       o_temp,
    output logic [22:0]              o_press
);
    import bsc_pkg::*;

    localparam int NST = 10;
    localparam int RPW = RAW_BITS + 1;

    logic [NST-1:0]     r_vld;
    logic [RPW-1:0]     r_rpu [7];
    logic signed [15:0] r_tmp [NST];

    logic signed [RPW-1:0] w_rp0;
    logic signed [RPW-1:0] w_rp1;
    logic signed [RPW-1:0] w_rp2;
    logic signed [RPW-1:0] w_rp3;
    logic signed [RPW-1:0] w_rp6;
    logic signed [16:0]    w_p1m;
    logic signed [16:0]    w_p2m;
    logic signed [16:0]    w_p5;
    logic signed [16:0]    w_p6;

    // stage 1
    logic signed [49:0] r1_sq;
    logic signed [41:0] r1_p6tq;
    logic signed [32:0] r1_p10tq;
    logic signed [49:0] r1_rr;
    logic signed [41:0] r1_p2tq;
    logic signed [24:0] r1_tq;
    // stage 2
    logic signed [49:0] w_sqr;
    logic signed [31:0] r2_tq2;
    logic signed [33:0] r2_a;
    logic signed [57:0] r2_rrp;
    logic signed [24:0] r2_tq;
    logic signed [41:0] r2_p6tq;
    logic signed [41:0] r2_p2tq;
    // stage 3
    logic signed [57:0] w_rrpr;
    logic signed [56:0] r3_c;
    logic signed [39:0] r3_p7tq2;
    logic signed [39:0] r3_p3tq2;
    logic signed [58:0] r3_ra;
    logic signed [33:0] r3_q2;
    logic signed [41:0] r3_p6tq;
    logic signed [41:0] r3_p2tq;
    // stage 4
    logic signed [56:0] w_cr;
    logic signed [58:0] w_rar;
    logic signed [40:0] r4_tq3;
    logic signed [34:0] r4_q1;
    logic signed [58:0] r4_w2;
    logic signed [41:0] r4_p6tq;
    logic signed [41:0] r4_p2tq;
    logic signed [39:0] r4_p7tq2;
    logic signed [39:0] r4_p3tq2;
    // stage 5
    logic signed [58:0] w_w2r;
    logic signed [48:0] r5_p8tq3;
    logic signed [48:0] r5_p4tq3;
    logic signed [59:0] r5_w1;
    logic signed [53:0] r5_h2;
    logic signed [41:0] r5_p6tq;
    logic signed [41:0] r5_p2tq;
    logic signed [39:0] r5_p7tq2;
    logic signed [39:0] r5_p3tq2;
    // stage 6
    logic signed [53:0] w_s;
    logic signed [59:0] w_off;
    logic signed [59:0] w_w1r;
    logic signed [53:0] r6_s;
    logic signed [59:0] r6_off;
    logic signed [55:0] r6_h1;
    logic signed [53:0] r6_h2;
    // stage 7
    logic signed [53:0] w_sr;
    logic signed [36:0] r7_s17;
    logic signed [61:0] r7_hs;
    // stage 8
    logic signed [61:0] r8_m;
    logic signed [61:0] r8_hs;
    // stage 9 and 10
    logic signed [63:0] r9_acc;
    logic signed [63:0] w_accr;
    logic signed [33:0] w_pq;
    logic [22:0]        r10_press;

    // raw pressure taps, each lined up with the stage that reads it
    assign w_rp0 = $signed({1'b0, i_rp});
    assign w_rp1 = $signed(r_rpu[1]);
    assign w_rp2 = $signed(r_rpu[2]);
    assign w_rp3 = $signed(r_rpu[3]);
    assign w_rp6 = $signed(r_rpu[6]);
    assign w_p1m = i_trims.p1 - 17'sd16384;
    assign w_p2m = i_trims.p2 - 17'sd16384;
    assign w_p5  = $signed({1'b0, i_trims.p5});
    assign w_p6  = $signed({1'b0, i_trims.p6});

    // rounding adds ahead of the truncating slices
    assign w_sqr  = r1_sq + 50'sd32768;
    assign w_rrpr = r2_rrp + 58'sd8388608;
    assign w_cr   = r3_c + 57'sd32768;
    assign w_rar  = r3_ra + 59'sd8388608;
    assign w_w2r  = r4_w2 + 59'sd16;
    assign w_w1r  = r5_w1 + 60'sd8;
    assign w_sr   = r6_s + 54'sd65536;
    assign w_accr = r9_acc + 64'sd536870912;
    assign w_pq   = w_accr[63:30];

    // sensitivity and offset polynomials
    assign w_s   = (w_p1m <<< 33) + (r5_p2tq <<< 8) + (r5_p3tq2 <<< 5) + r5_p4tq3;
    assign w_off = (w_p5 <<< 39) + (r5_p6tq <<< 14) + (r5_p7tq2 <<< 12)
                 + (r5_p8tq3 <<< 5);

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // raw pressure and temperature carried along
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rpu[0] <= w_rp0;
            for (int k = 1; k < 7; k++) begin
                r_rpu[k] <= r_rpu[k-1];
            end
            r_tmp[0] <= i_temp;
            for (int k = 1; k < NST; k++) begin
                r_tmp[k] <= r_tmp[k-1];
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // first products of temperature and raw pressure
            r1_sq    <= i_tq * i_tq;
            r1_p6tq  <= w_p6 * i_tq;
            r1_p10tq <= i_trims.p10 * i_tq;
            r1_rr    <= w_rp0 * w_rp0;
            r1_p2tq  <= w_p2m * i_tq;
            r1_tq    <= i_tq;
            // square, cubic raw term
            r2_tq2  <= w_sqr[47:16];
            r2_a    <= (34'(i_trims.p9) <<< 16) + r1_p10tq;
            r2_rrp  <= r1_rr * i_trims.p11;
            r2_tq   <= r1_tq;
            r2_p6tq <= r1_p6tq;
            r2_p2tq <= r1_p2tq;
            // cube product, square terms
            r3_c     <= r2_tq2 * r2_tq;
            r3_p7tq2 <= i_trims.p7 * r2_tq2;
            r3_p3tq2 <= i_trims.p3 * r2_tq2;
            r3_ra    <= w_rp1 * r2_a;
            r3_q2    <= w_rrpr[57:24];
            r3_p6tq  <= r2_p6tq;
            r3_p2tq  <= r2_p2tq;
            // cube, second raw products
            r4_tq3   <= w_cr[56:16];
            r4_q1    <= w_rar[58:24];
            r4_w2    <= r3_q2 * w_rp2;
            r4_p6tq  <= r3_p6tq;
            r4_p2tq  <= r3_p2tq;
            r4_p7tq2 <= r3_p7tq2;
            r4_p3tq2 <= r3_p3tq2;
            // cube terms
            r5_p8tq3 <= i_trims.p8 * r4_tq3;
            r5_p4tq3 <= i_trims.p4 * r4_tq3;
            r5_w1    <= r4_q1 * w_rp3;
            r5_h2    <= w_w2r[58:5];
            r5_p6tq  <= r4_p6tq;
            r5_p2tq  <= r4_p2tq;
            r5_p7tq2 <= r4_p7tq2;
            r5_p3tq2 <= r4_p3tq2;
            // polynomial sums
            r6_s   <= w_s;
            r6_off <= w_off;
            r6_h1  <= w_w1r[59:4];
            r6_h2  <= r5_h2;
            // sensitivity rounding, offset plus higher-order terms
            r7_s17 <= w_sr[53:17];
            r7_hs  <= r6_off + r6_h1 + r6_h2;
            // sensitivity times raw pressure
            r8_m  <= w_rp6 * r7_s17;
            r8_hs <= r7_hs;
            // accumulate
            r9_acc <= r8_hs + r8_m;
            // round and saturate
            if (w_pq < 34'sd0) begin
                r10_press <= '0;
            end else if (w_pq > 34'sd8388607) begin
                r10_press <= 23'h7fffff;
            end else begin
                r10_press <= w_pq[22:0];
            end
        end
    end

    assign o_vld   = r_vld[NST-1];
    assign o_temp  = r_tmp[NST-1];
    assign o_press = r10_press;

endmodule

`default_nettype wire

@@ src/baro_sensor_compensation.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | i_valid / o_stall  | i_raw_pressure, i_raw_temperature
// output   | o_valid / i_stall  | o_temperature_out, o_pressure_out
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// one item per cycle while the pipeline is not held; 5 temperature stages and
// 10 pressure stages, the last one being the output register
// the whole pipeline advances together; it holds only while the output
// register is full and i_stall is high, so o_stall follows i_stall then
// synchronous active-low reset clears all valid bits and the trim registers

module baro_sensor_compensation #(
    parameter int RAW_BITS = bsc_pkg::RAW_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [RAW_BITS-1:0]            i_raw_pressure,
    input  wire logic [RAW_BITS-1:0]            i_raw_temperature,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [15:0]                  o_temperature_out,
    output logic [22:0]                         o_pressure_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bsc_pkg::*;

    t_trims                w_trims;
    logic                  w_en;
    logic                  w_t_vld;
    logic [RAW_BITS-1:0]   w_t_rp;
    logic signed [15:0]    w_t_temp;
    logic signed [24:0]    w_t_tq;

    // pipeline advance
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    bsc_trim u_trim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_trims    (w_trims)
    );

    bsc_temp #(
        .RAW_BITS (RAW_BITS)
    ) u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_rp    (i_raw_pressure),
        .i_rt    (i_raw_temperature),
        .i_trims (w_trims),
        .o_vld   (w_t_vld),
        .o_rp    (w_t_rp),
        .o_temp  (w_t_temp),
        .o_tq    (w_t_tq)
    );

    bsc_press #(
        .RAW_BITS (RAW_BITS)
    ) u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_t_vld),
        .i_rp    (w_t_rp),
        .i_temp  (w_t_temp),
        .i_tq    (w_t_tq),
        .i_trims (w_trims),
        .o_vld   (o_valid),
        .o_temp  (o_temperature_out),
        .o_press (o_pressure_out)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    typedef struct packed {
        logic [23:0] raw_p;
        logic [23:0] raw_t;
    } t_raw_pair;

    typedef struct packed {
        logic signed [15:0] temp;
        logic        [22:0] press;
    } t_reading;

    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD   = 120;
    localparam int DRAIN_WAIT  = 20;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [23:0]        i_raw_pressure;
    logic [23:0]        i_raw_temperature;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_temperature_out;
    logic [22:0]        o_pressure_out;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_raw_pair pending_pairs[$];
    t_reading  expected_readings[$];

    // model copy of the trim registers
    logic [39:0] trim_temp;
    logic [47:0] trim_pa;
    logic [47:0] trim_pb;
    logic [31:0] trim_pc;

    logic in_took;
    logic out_took;
    logic quiet;
    logic hold_req;
    int   mismatches;
    int   idle_cycles;
    int   send_gap;
    int   recv_gap;
    int   hold_cnt;

    baro_sensor_compensation dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_temperature_out (o_temperature_out),
        .o_pressure_out    (o_pressure_out),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // divide by 2^n rounding half up
    function automatic longint round_down_by(longint x, int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        return (x + half) >>> n;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // compensated reading for one raw pair under the current trims
    function automatic t_reading compensate(t_raw_pair pair);
        longint rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint d, t48, tc, tq, tq2, tq3, sens, a, acc, pc;
        t_reading r;
        rp  = longint'(pair.raw_p);
        rt  = longint'(pair.raw_t);
        t1  = longint'(trim_temp[15:0]);
        t2  = longint'(trim_temp[31:16]);
        t3  = longint'($signed(trim_temp[39:32]));
        p1  = longint'($signed(trim_pa[15:0]));
        p2  = longint'($signed(trim_pa[31:16]));
        p3  = longint'($signed(trim_pa[39:32]));
        p4  = longint'($signed(trim_pa[47:40]));
        p5  = longint'(trim_pb[15:0]);
        p6  = longint'(trim_pb[31:16]);
        p7  = longint'($signed(trim_pb[39:32]));
        p8  = longint'($signed(trim_pb[47:40]));
        p9  = longint'($signed(trim_pc[15:0]));
        p10 = longint'($signed(trim_pc[23:16]));
        p11 = longint'($signed(trim_pc[31:24]));

        // linearised temperature
        d   = rt - t1 * 256;
        t48 = d * t2 * 262144 + d * d * t3;
        tc  = clip(round_down_by(t48, 40), -32768, 32767);
        tq  = clip(round_down_by(t48, 32), -(longint'(1) <<< 23), longint'(1) <<< 23);
        tq2 = round_down_by(tq * tq, 16);
        tq3 = round_down_by(tq2 * tq, 16);

        // offset, sensitivity and higher-order raw pressure terms
        acc  = p5 * (longint'(1) <<< 39) + p6 * tq * 16384 + p7 * tq2 * 4096
             + p8 * tq3 * 32;
        sens = (p1 - 16384) * (longint'(1) <<< 33) + (p2 - 16384) * tq * 256
             + p3 * tq2 * 32 + p4 * tq3;
        acc += rp * round_down_by(sens, 17);
        a    = p9 * 65536 + p10 * tq;
        acc += round_down_by(round_down_by(rp * a, 24) * rp, 4);
        acc += round_down_by(round_down_by(rp * rp * p11, 24) * rp, 5);
        pc   = clip(round_down_by(acc, 30), 0, 8388607);

        r.temp  = tc[15:0];
        r.press = pc[22:0];
        return r;
    endfunction

    // accept tracking, prediction, checking and trim shadowing
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        in_took  <= i_rst_n && i_valid && !o_stall;
        out_took <= i_rst_n && o_valid && !i_stall;
        if (!i_rst_n) begin
            trim_temp <= '0;
            trim_pa   <= '0;
            trim_pb   <= '0;
            trim_pc   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEMP_TRIM:    trim_temp <= i_cfg_data[39:0];
                    REG_PRESS_TRIM_A: trim_pa   <= i_cfg_data[47:0];
                    REG_PRESS_TRIM_B: trim_pb   <= i_cfg_data[47:0];
                    REG_PRESS_TRIM_C: trim_pc   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_readings.push_back(compensate({i_raw_pressure, i_raw_temperature}));
            if (o_valid && !i_stall) begin
                got = {o_temperature_out, o_pressure_out};
                if (expected_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item temp=%0d press=%0d", $time,
                             o_temperature_out, o_pressure_out);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.temp !== want.temp) begin
                        mismatches++;
                        $display("%0t: temperature expected %0d got %0d", $time,
                                 want.temp, got.temp);
                    end
                    if (got.press !== want.press) begin
                        mismatches++;
                        $display("%0t: pressure expected %0d got %0d", $time,
                                 want.press, got.press);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // sender
    always @(negedge i_clk) begin
        t_raw_pair nxt;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else if (i_valid && !in_took) begin
            // offered item still waiting, keep it
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
            nxt = pending_pairs.pop_front();
            i_raw_pressure    <= nxt.raw_p;
            i_raw_temperature <= nxt.raw_t;
            i_valid           <= 1'b1;
            send_gap = quiet ? 0 : $urandom_range(0, 3);
        end else
            i_valid <= 1'b0;
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap = 0;
            hold_cnt = 0;
        end else begin
            if (hold_req && hold_cnt == 0)
                hold_cnt = LONG_HOLD;
            if (out_took)
                recv_gap = quiet ? 0 : $urandom_range(0, 3);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else
                i_stall <= 1'b0;
        end
    end

    task automatic write_trim(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_trims(logic [39:0] tt, logic [47:0] pa, logic [47:0] pb,
                              logic [31:0] pc);
        write_trim(REG_TEMP_TRIM, {8'h00, tt});
        write_trim(REG_PRESS_TRIM_A, pa);
        write_trim(REG_PRESS_TRIM_B, pb);
        write_trim(REG_PRESS_TRIM_C, {16'h0000, pc});
    endtask

    task automatic push_pair(logic [23:0] p, logic [23:0] t);
        t_raw_pair x;
        x.raw_p = p;
        x.raw_t = t;
        pending_pairs.push_back(x);
    endtask

    // edge values of both raw fields
    task automatic push_edges();
        push_pair(24'h000000, 24'h000000);
        push_pair(24'hFFFFFF, 24'hFFFFFF);
        push_pair(24'h000000, 24'hFFFFFF);
        push_pair(24'hFFFFFF, 24'h000000);
        push_pair(24'h800000, 24'h800000);
        push_pair(24'h7FFFFF, 24'h7FFFFF);
        push_pair(24'h000001, 24'h000001);
        push_pair(24'h555555, 24'hAAAAAA);
        push_pair(24'hAAAAAA, 24'h555555);
        push_pair({trim_temp[15:0], 8'h00}, {trim_temp[15:0], 8'h00});
    endtask

    // about half raw temperatures near the trim zero point, the rest anything
    task automatic push_random(int n);
        logic [23:0] t;
        repeat (n) begin
            if ($urandom_range(0, 1))
                t = {trim_temp[15:0], 8'h00} + 24'($urandom_range(0, 2000000)) - 24'd1000000;
            else
                t = 24'($urandom);
            push_pair(24'($urandom), t);
        end
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // stimulus phases
    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_raw_pressure    = '0;
        i_raw_temperature = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_TEMP_TRIM;
        i_cfg_data        = '0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        mismatches        = 0;
        idle_cycles       = 0;
        in_took           = 1'b0;
        out_took          = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // trims at reset value
        push_edges();
        push_random(150);
        drain();

        // typical trims, with a long receiver hold-off
        load_trims({8'hF9, 16'd19000, 16'd27000}, {8'h02, 8'hFC, 16'd300, 16'd2000},
                   {8'hFE, 8'h03, 16'd40000, 16'd30000}, {8'h01, 8'hFF, 16'd500});
        push_edges();
        push_random(400);
        hold_req = 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        hold_req = 1'b0;
        drain();

        // all ones
        load_trims('1, '1, '1, '1);
        push_edges();
        push_random(250);
        drain();

        // most negative signed trims, largest unsigned ones
        load_trims({8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000, 16'h8000},
                   {8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000});
        push_edges();
        push_random(250);
        drain();

        // random trims, one phase without idling
        repeat (3) begin
            load_trims(40'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}), 32'($urandom));
            push_random(300);
            drain();
            quiet = ~quiet;
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
